[src/http_header_name_matcher_core_defines.svh]
// assertion macros for the header name matcher
`ifndef HTTP_HEADER_NAME_MATCHER_CORE_DEFINES_SVH
`define HTTP_HEADER_NAME_MATCHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, idle while reset is held
`define HHNM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define HHNM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define HHNM_ASSERT(label, prop, msg)
`define HHNM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[src/hhnm_pkg.sv]
// constants, name table and helper functions for the header name matcher
package hhnm_pkg;

    localparam int NAME_COUNT    = 70;
    localparam int MAX_NAME_LEN  = 27;
    localparam int TABLE_ENTRIES = 70;
    localparam int SLOT_BYTES    = 31;
    localparam int ROW_BYTES     = 32;
    localparam int CNT_W         = 5;
    localparam int IDX_W         = 7;
    localparam int BYTE_W        = 8;
    localparam int OUT_TDATA_W   = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // names are right aligned: last character in the lowest byte
    localparam logic [BYTE_W*SLOT_BYTES-1:0] HDR_TABLE [TABLE_ENTRIES] = '{
        "Te", "Age", "Dnt", "Via", "P3p",
        "Host", "Date", "Etag", "Vary", "Link",
        "Allow", "Range",
        "Cookie", "Accept", "Status", "Server", "Expect", "Pragma",
        "Warning", "Upgrade", "Referer", "Trailer", "Expires", "Alt-Svc",
        "Location", "Priority", "If-Match", "If-Range", "Alt-Used",
        "Forwarded", "Expect-Ct",
        "Connection", "Set-Cookie", "User-Agent", "Content-Id",
        "Retry-After", "Content-MD5",
        "Content-Type",
        "Last-Modified", "Authorization", "If-None-Match", "Cache-Control",
        "Accept-Ranges", "Content-Range",
        "Content-Length", "HTTP2-Settings", "Onion-Location",
        "Accept-Encoding", "Accept-Language", "Referrer-Policy",
        "X-Forwarded-For", "X-Frame-Options",
        "Content-Language", "WWW-Authenticate", "Content-Encoding",
        "Content-Location", "X-XSS-Protection",
        "If-Modified-Since", "Transfer-Encoding", "X-Forwarded-Proto",
        "Proxy-Authenticate",
        "Proxy-Authorization", "If-Unmodified-Since", "Content-Disposition",
        "X-Content-Type-Options",
        "Content-Security-Policy",
        "Strict-Transport-Security", "Upgrade-Insecure-Requests",
        "Content-Transfer-Encoding",
        "Access-Control-Allow-Origin"
    };

    // ascii lower-case fold, only A-Z change
    function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
        if (c inside {["A":"Z"]}) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // name length of a slot, zero for an empty slot
    function automatic logic [CNT_W-1:0] slot_len(input int idx);
        int n;
        n = 0;
        if (idx < TABLE_ENTRIES) begin
            for (int b = 0; b < SLOT_BYTES; b++) begin
                if (HDR_TABLE[idx][b*BYTE_W +: BYTE_W] != '0) begin
                    n = b + 1;
                end
            end
        end
        return CNT_W'(n);
    endfunction

    // folded characters of a slot in position order, position 0 lowest
    function automatic logic [BYTE_W*ROW_BYTES-1:0] slot_row(input int idx);
        logic [BYTE_W*ROW_BYTES-1:0] row;
        int len;
        row = '0;
        len = int'(slot_len(idx));
        if (idx < TABLE_ENTRIES) begin
            for (int p = 0; p < len; p++) begin
                row[p*BYTE_W +: BYTE_W] =
                    fold_lower(HDR_TABLE[idx][(len-1-p)*BYTE_W +: BYTE_W]);
            end
        end
        return row;
    endfunction

endpackage

[src/http_header_name_matcher_core.sv]
// http header field name matcher: byte stream in, match result out
//
// input channel (s side): one byte of a header field name per transfer,
//   tlast set on the final byte. output channel (m side): one transfer per
//   name, carrying found and the index of the matching name in the
//   length-sorted table of 70 standard header names (index 0 if not found).
// comparison ignores ascii case (only A-Z fold); all 70 names are checked
//   in parallel against the byte at the current position.
// throughput: one byte per cycle while o_s_tready is high, set by the combinational compare of the
//   incoming byte against every table column at the current position.
// the result is registered: it is in the output register in the cycle after the
//   transfer of the final byte.
// names longer than 27 bytes never match; the position count saturates.
// reset (synchronous, active low) clears the position count, sets every
//   still-matching mark and empties the output register.
// when the receiver stalls, the result holds in the output register; input
//   bytes keep flowing unless a result is waiting and is not being taken.
`include "http_header_name_matcher_core_defines.svh"

module http_header_name_matcher_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // byte input
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [hhnm_pkg::BYTE_W-1:0]      i_s_tdata,   // [7:0] key_byte
    input  logic                             i_s_tlast,   // last byte of the name
    // match result
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [hhnm_pkg::OUT_TDATA_W-1:0] o_m_tdata    // [0] found, [7:1] header_index
);
    import hhnm_pkg::*;

    // per-name state and position count
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [NAME_COUNT-1:0] r_alive;
    logic [NAME_COUNT-1:0] n_alive;
    logic [NAME_COUNT-1:0] alive_now;   // marks after this byte
    logic [NAME_COUNT-1:0] hit;         // marks that end exactly here

    // result register
    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_out_index;
    logic                  r_out_found;

    logic                  s_fire;
    logic                  end_fire;
    logic [BYTE_W-1:0]     key_fold;
    logic                  len_ok;
    logic [IDX_W-1:0]      hit_index;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign end_fire   = s_fire && i_s_tlast;
    assign key_fold   = fold_lower(i_s_tdata);
    // length limit: count is the position, so count < max means total <= max
    assign len_ok     = ({1'b0, r_count} < (CNT_W+1)'(MAX_NAME_LEN));

    // one comparator column per stored name
    for (genvar g = 0; g < NAME_COUNT; g++) begin : g_name
        localparam logic [BYTE_W*ROW_BYTES-1:0] ROW    = slot_row(g);
        localparam logic [CNT_W-1:0]            LEN    = slot_len(g);
        localparam logic [CNT_W-1:0]            LEN_M1 = LEN - CNT_W'(1);

        logic [BYTE_W-1:0] ref_char;
        assign ref_char     = ROW[{r_count, 3'b000} +: BYTE_W];
        assign alive_now[g] = r_alive[g] && (r_count < LEN) && (ref_char == key_fold);
        assign hit[g]       = alive_now[g] && (r_count == LEN_M1) && len_ok;
    end

    // names are unique, so at most one hit: or the indexes together
    always_comb begin
        hit_index = '0;
        for (int i = 0; i < NAME_COUNT; i++) begin
            if (hit[i]) begin
                hit_index = hit_index | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_alive = r_alive;
        if (s_fire) begin
            if (i_s_tlast) begin
                n_count = '0;
                n_alive = '1;
            end else begin
                n_alive = alive_now;
                if (r_count != CNT_MAX) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_alive     <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_alive <= n_alive;
            if (o_s_tready) begin
                r_out_valid <= end_fire;
            end
        end
    end

    // payload of the result register
    always_ff @(posedge i_clk) begin
        if (end_fire) begin
            r_out_found <= |hit;
            r_out_index <= hit_index;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_index, r_out_found};

    // a name never matches more than one table entry
    `HHNM_ASSERT(a_single_hit, $onehot0(hit), "more than one header name matched")
    // the end of a name restarts the position count and all marks
    `HHNM_ASSERT(a_restart, end_fire |=> (r_count == '0) && (&r_alive), "no restart after last byte")
    // a new result only follows a last byte transfer
    `HHNM_ASSERT(a_result_src, $rose(o_m_tvalid) |-> $past(end_fire), "result without last byte")
    // a miss always reports index zero
    `HHNM_ASSERT(a_miss_index, (o_m_tvalid && !r_out_found) |-> (r_out_index == '0), "miss with nonzero index")

endmodule

[tb/sv/hhnm_match_checker.sv]
// scoreboard for the header name matcher: predicts each match result and compares it
module hhnm_match_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] key_byte
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [0] found, [7:1] header_index
    output int         o_fail_count,
    output int         o_pending
);
    import hhnm_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] header_index;
        logic             found;
    } t_match_result;

    string header_names [NAME_COUNT] = '{
        "Te", "Age", "Dnt", "Via", "P3p",
        "Host", "Date", "Etag", "Vary", "Link",
        "Allow", "Range",
        "Cookie", "Accept", "Status", "Server", "Expect", "Pragma",
        "Warning", "Upgrade", "Referer", "Trailer", "Expires", "Alt-Svc",
        "Location", "Priority", "If-Match", "If-Range", "Alt-Used",
        "Forwarded", "Expect-Ct",
        "Connection", "Set-Cookie", "User-Agent", "Content-Id",
        "Retry-After", "Content-MD5",
        "Content-Type",
        "Last-Modified", "Authorization", "If-None-Match", "Cache-Control",
        "Accept-Ranges", "Content-Range",
        "Content-Length", "HTTP2-Settings", "Onion-Location",
        "Accept-Encoding", "Accept-Language", "Referrer-Policy",
        "X-Forwarded-For", "X-Frame-Options",
        "Content-Language", "WWW-Authenticate", "Content-Encoding",
        "Content-Location", "X-XSS-Protection",
        "If-Modified-Since", "Transfer-Encoding", "X-Forwarded-Proto",
        "Proxy-Authenticate",
        "Proxy-Authorization", "If-Unmodified-Since", "Content-Disposition",
        "X-Content-Type-Options",
        "Content-Security-Policy",
        "Strict-Transport-Security", "Upgrade-Insecure-Requests",
        "Content-Transfer-Encoding",
        "Access-Control-Allow-Origin"
    };

    logic [CNT_W-1:0]      name_pos       = '0;
    logic [NAME_COUNT-1:0] still_matching = '1;
    t_match_result         expected_results[$];
    int                    errors = 0;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // one name byte: narrow the candidates, and on the final byte queue the result
    task automatic match_byte(input logic [7:0] key, input logic final_byte);
        int            total;
        t_match_result res;
        for (int i = 0; i < NAME_COUNT; i++) begin
            if (int'(name_pos) >= header_names[i].len() ||
                to_lower(header_names[i][name_pos]) != to_lower(key)) begin
                still_matching[i] = 1'b0;
            end
        end
        if (!final_byte) begin
            if (name_pos != CNT_MAX) begin
                name_pos = name_pos + 1'b1;
            end
        end else begin
            total = int'(name_pos) + 1;
            res   = '0;
            if (total <= MAX_NAME_LEN) begin
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (!res.found && still_matching[i] &&
                        header_names[i].len() == total) begin
                        res.found        = 1'b1;
                        res.header_index = IDX_W'(i);
                    end
                end
            end
            expected_results.push_back(res);
            name_pos       = '0;
            still_matching = '1;
        end
    endtask

    always @(posedge i_clk) begin
        t_match_result got;
        t_match_result want;
        if (!i_rst_n) begin
            name_pos       = '0;
            still_matching = '1;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                match_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_results.size() == 0) begin
                    $error("match result with nothing expected: tdata %h", i_m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        errors++;
                    end
                    if (got.header_index !== want.header_index) begin
                        $error("header_index: expected %0d, actual %0d",
                               want.header_index, got.header_index);
                        errors++;
                    end
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_results.size();
    end

endmodule

[tb/sv/http_header_name_matcher_core_tb.sv]
// testbench top for the header name matcher: clock, reset, name stimulus and verdict
module http_header_name_matcher_core_tb;
    import hhnm_pkg::*;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [BYTE_W-1:0]      i_s_tdata  = '0;    // [7:0] key_byte
    logic                   i_s_tlast  = 1'b0;  // final byte of the name
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // [0] found, [7:1] header_index

    int         fail_count;
    int         pending;
    logic [7:0] name_bytes[$];   // the name about to be sent, first byte at the front
    int         bytes_sent = 0;
    bit         tx_calm    = 1'b0;   // sender runs without gaps while set
    bit         rx_calm    = 1'b0;   // receiver runs without stalls while set

    http_header_name_matcher_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    hhnm_match_checker u_match_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly no gap, some short ones, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // the package table holds names right aligned, last character in byte 0
    function automatic int table_len(input int k);
        int n;
        n = 0;
        while (n < SLOT_BYTES && HDR_TABLE[k][n*BYTE_W +: BYTE_W] != 8'h00) n++;
        return n;
    endfunction

    function automatic logic [7:0] table_char(input int k, input int p);
        return HDR_TABLE[k][(table_len(k)-1-p)*BYTE_W +: BYTE_W];
    endfunction

    task automatic load_text(input string s);
        name_bytes.delete();
        for (int i = 0; i < s.len(); i++) name_bytes.push_back(s[i]);
    endtask

    // random name: mostly stored names in random case, some damaged, some longest names
    // with a tail, the rest raw bytes of any length, including names past the count limit
    task automatic build_random_name();
        int         r;
        int         k;
        int         n;
        int         p;
        logic [7:0] c;
        name_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 70) begin
            k = $urandom_range(0, NAME_COUNT - 1);
            n = table_len(k);
            for (p = 0; p < n; p++) begin
                c = table_char(k, p);
                if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                    $urandom_range(0, 1) == 1) begin
                    c = c ^ 8'h20;
                end
                name_bytes.push_back(c);
            end
            p = $urandom_range(0, n - 1);
            case ($urandom_range(0, 7))
                // any byte in place of one character
                0: name_bytes[p] = 8'($urandom_range(0, 255));
                // bit 5 flipped: harmless on letters, a mismatch on anything else
                1: name_bytes[p] = name_bytes[p] ^ 8'h20;
                // one byte short, so a prefix of a longer name
                2: if (n > 1) void'(name_bytes.pop_back());
                // one byte past the end of the name
                3: name_bytes.push_back(8'($urandom_range(32, 126)));
                // cut down to a random prefix
                4: while (name_bytes.size() > p + 1) void'(name_bytes.pop_back());
                default: ;
            endcase
        end else if (r < 85) begin
            n = $urandom_range(1, 12);
            repeat (n) name_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (r < 93) begin
            // longest stored names with a tail, so the name may run past the limit
            k = $urandom_range(NAME_COUNT - 4, NAME_COUNT - 1);
            n = table_len(k);
            for (p = 0; p < n; p++) name_bytes.push_back(table_char(k, p));
            repeat ($urandom_range(1, 14)) name_bytes.push_back(8'($urandom_range(32, 126)));
        end else begin
            n = $urandom_range(13, 40);
            repeat (n) name_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // send the buffered name, one transfer per byte, tlast on the final one
    task automatic send_name();
        int gap;
        for (int p = 0; p < name_bytes.size(); p++) begin
            gap = tx_calm ? 0 : pick_gap();
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= name_bytes[p];
            i_s_tlast  <= (p == name_bytes.size() - 1);
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    // result side: random stalls, with calm stretches now and then
    initial begin : result_sink
        int stall_left;
        int cycles;
        stall_left = 0;
        cycles     = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles % 250 == 0) rx_calm = ($urandom_range(0, 2) == 0);
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                if (!rx_calm) stall_left = pick_gap();
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte extremes in a two-byte name that matches nothing
        name_bytes = '{8'h00, 8'hFF};
        send_name();
        // length one has no stored names
        load_text("x");
        send_name();
        // first table entry, case swapped
        load_text("tE");
        send_name();
        // last table entry at the longest length, case swapped
        load_text("aCCESS-cONTROL-aLLOW-oRIGIN");
        send_name();

        while (bytes_sent < 1400) begin
            if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
            build_random_name();
            send_name();
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        // the pending count is registered, so it lags behind the last transfer
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/hhnm_pkg.sv
src/http_header_name_matcher_core.sv
tb/sv/hhnm_match_checker.sv
tb/sv/http_header_name_matcher_core_tb.sv
